@@ rtl/core/xur_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xur_pkg
// types, command codes and the xorshift round for the uniform rng core
// ----------------------------------------------------------------------------
package xur_pkg;

    localparam logic [63:0] GOLDEN_WORD   = 64'h9E37_79B9_7F4A_7C15;
    localparam int          WARMUP_ROUNDS = 4;
    localparam int          SHIFT_A       = 13;
    localparam int          SHIFT_B       = 7;
    localparam int          SHIFT_C       = 17;

    localparam logic [1:0] CMD_SEED    = 2'd0;
    localparam logic [1:0] CMD_NEXT    = 2'd1;
    localparam logic [1:0] CMD_UNIFORM = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seed_value;
        logic [31:0] range_n;
    } t_rng_in;

    typedef struct packed {
        logic [31:0] random_value;
        logic        range_error;
    } t_rng_out;

    function automatic logic [63:0] advance(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

    // state after seeding with zero
    localparam logic [63:0] RESET_STATE =
        advance(advance(advance(advance(GOLDEN_WORD))));

endpackage

@@ rtl/core/xorshift_uniform_rng_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift_uniform_rng_core
// 64-bit xorshift generator with seeding and unbiased draws below a range
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       slave      i_in_valid / o_in_ready / i_in_data (command, seed, range)
// out      master     o_out_valid / i_out_ready / o_out_data (value, error)
//
// seed loads the state and runs the warm-up rounds; next32 makes one draw; a zero
// range or an unused code goes straight to the output step
// uniform runs two passes of the radix-4 remainder unit (rejection limit, then
// value mod n) with the draw step between them, then the output step and idle
// each rejected draw repeats the draw step; one item at a time, ready only when idle
// reset is synchronous and loads the state that seeding with zero gives
// a stalled output register holds the block in its final step
// ----------------------------------------------------------------------------
module xorshift_uniform_rng_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  xur_pkg::t_rng_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output xur_pkg::t_rng_out o_out_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED  = 3'd1;
    localparam logic [2:0] S_LIMIT = 3'd2;
    localparam logic [2:0] S_DRAW  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  r_fsm;
    logic [63:0] r_gen;
    logic [3:0]  r_cnt;
    logic        r_uni;
    logic [31:0] r_n;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [31:0] r_lim;
    logic [31:0] r_val;
    logic        r_err;
    logic        r_out_valid;
    xur_pkg::t_rng_out r_out_data;

    logic [63:0] n_gen;
    logic [63:0] n_seed;
    logic [31:0] n_rem;
    logic [32:0] n_sum;
    logic        out_free;
    logic        in_xfer;

    assign n_gen    = xur_pkg::advance(r_gen);
    assign n_seed   = {i_in_data.seed_value, i_in_data.seed_value} ^ xur_pkg::GOLDEN_WORD;
    assign n_sum    = {1'b0, n_gen[63:32]} + {1'b0, r_lim};
    assign out_free = !r_out_valid || i_out_ready;
    assign in_xfer  = i_in_valid && o_in_ready;

    // shared remainder unit, two restoring steps a cycle
    always_comb begin
        logic [31:0] rem_w;
        logic [31:0] div_w;
        logic [32:0] trial;
        rem_w = r_rem;
        div_w = r_div;
        for (int k = 0; k < 2; k++) begin
            trial = {rem_w, div_w[31]};
            div_w = {div_w[30:0], 1'b0};
            if (trial >= {1'b0, r_n}) begin
                rem_w = 32'(trial - {1'b0, r_n});
            end else begin
                rem_w = trial[31:0];
            end
        end
        n_rem = rem_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_gen       <= xur_pkg::RESET_STATE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if ((r_fsm == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_val <= '0;
                        r_err <= 1'b0;
                        r_n   <= i_in_data.range_n;
                        r_rem <= '0;
                        r_div <= 32'd0 - i_in_data.range_n;
                        r_cnt <= 4'hF;
                        unique case (i_in_data.command)
                            xur_pkg::CMD_SEED: begin
                                r_gen <= (n_seed == '0) ? xur_pkg::GOLDEN_WORD : n_seed;
                                r_cnt <= 4'(xur_pkg::WARMUP_ROUNDS - 1);
                                r_fsm <= S_SEED;
                            end
                            xur_pkg::CMD_NEXT: begin
                                r_uni <= 1'b0;
                                r_fsm <= S_DRAW;
                            end
                            xur_pkg::CMD_UNIFORM: begin
                                r_uni <= 1'b1;
                                if (i_in_data.range_n == '0) begin
                                    r_err <= 1'b1;
                                    r_fsm <= S_OUT;
                                end else begin
                                    r_fsm <= S_LIMIT;
                                end
                            end
                            default: begin
                                r_fsm <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SEED: begin
                    r_gen <= n_gen;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == '0) begin
                        r_fsm <= S_OUT;
                    end
                end
                S_LIMIT: begin
                    r_rem <= n_rem;
                    r_div <= {r_div[29:0], 2'b00};
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == '0) begin
                        r_lim <= n_rem;
                        r_fsm <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_gen <= n_gen;
                    if (!r_uni) begin
                        r_val <= n_gen[63:32];
                        r_fsm <= S_OUT;
                    end else if (!n_sum[32]) begin
                        r_div <= n_gen[63:32];
                        r_rem <= '0;
                        r_cnt <= 4'hF;
                        r_fsm <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_div <= {r_div[29:0], 2'b00};
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == '0) begin
                        r_val <= n_rem;
                        r_fsm <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_data.random_value <= r_val;
                        r_out_data.range_error  <= r_err;
                        r_fsm                   <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // one item in flight at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("ready stayed high after an input transfer");

    // the generator never falls into the all-zero state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generator state is zero");

    // remainder stays below the range while dividing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_LIMIT || r_fsm == S_MOD) |-> (r_rem < r_n))
        else $error("remainder not below range");

    // an error result carries a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |-> (o_out_data.random_value == '0))
        else $error("range error with non-zero value");

    // a result is loaded only from the output step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_fsm) == S_OUT))
        else $error("result loaded outside the output step");

endmodule
